// ----- src/sdf_pkg.sv -----
// Shared constants, state encoding and the converter-to-emitter hand-over for the formatter.
`timescale 1ns / 1ps

package sdf_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int DIGITS   = 10;
    localparam int DIGIT_W  = 4;
    localparam int BCD_W    = DIGITS * DIGIT_W;
    localparam int SHIFT_W  = $clog2(VALUE_W);
    localparam int REM_W    = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SIGN,
        EM_SKIP,
        EM_DIGIT
    } em_state_t;

    // Finished conversion handed from the converter to the emitter.
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } conv_res_t;

endpackage

// ----- src/signed_decimal_formatter.sv -----
// Top level of the signed decimal formatter: sign handling and the two serial stages.
`timescale 1ns / 1ps

// The block takes a signed 32-bit value when start is high and busy is low, and
// then writes out its decimal text as ASCII, one character per beat on character,
// each beat marked by a one-cycle pulse on strobe; last is high on the final beat.
// A negative value is led by '-', leading zeros are dropped and zero prints as a
// single '0'; the most negative value prints correctly as -2147483648. The
// receiver cannot hold beats off, so it must take every strobe as it comes. The
// shift-and-add-three converter consumes one magnitude bit per cycle and hands
// its result over to the emitter, which then writes the sign if any, skips the
// leading zeros and writes the digits, one per beat. The skipped zeros and the
// digits always add up to ten. Characters of one number need not arrive in
// consecutive cycles. Busy falls while the last beat is on the ports, so the
// next value may be started then.

module signed_decimal_formatter
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sdf_pkg::VALUE_W-1:0] value,
    output logic [sdf_pkg::CHAR_W-1:0]         character,
    output logic                               last,
    output logic                               strobe
);

    logic                        accept;
    logic                        neg;
    logic [sdf_pkg::VALUE_W-1:0] mag;
    logic                        conv_active;
    logic                        emit_active;
    sdf_pkg::conv_res_t          conv_res;

    assign accept = start && !busy;

    // The magnitude is taken as unsigned, so negating the most negative value
    // gives its true magnitude.
    assign neg = value[sdf_pkg::VALUE_W-1];
    assign mag = neg ? (sdf_pkg::VALUE_W'(0) - $unsigned(value)) : $unsigned(value);

    sdf_conv u_conv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .neg    (neg),
        .mag    (mag),
        .active (conv_active),
        .res    (conv_res)
    );

    sdf_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (conv_res),
        .active    (emit_active),
        .character (character),
        .last      (last),
        .strobe    (strobe)
    );

    assign busy = conv_active | emit_active;

endmodule

// ----- src/sdf_conv.sv -----
// Bit-serial binary-to-BCD converter (shift and add three), one input bit per cycle.
`timescale 1ns / 1ps

module sdf_conv
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          neg,
    input  logic [sdf_pkg::VALUE_W-1:0]   mag,
    output logic                          active,
    output sdf_pkg::conv_res_t            res
);

    logic [sdf_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [sdf_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [sdf_pkg::SHIFT_W-1:0] cnt_reg, cnt_next;
    logic                        active_reg, active_next;
    logic                        valid_reg, valid_next;
    logic                        neg_reg, neg_next;
    logic [sdf_pkg::BCD_W-1:0]   bcd_adj;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int d = 0; d < sdf_pkg::DIGITS; d++)
        begin
            bcd_adj[d*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] =
                (bcd_reg[d*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] >= sdf_pkg::DIGIT_FIVE)
                ? bcd_reg[d*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] + sdf_pkg::DIGIT_ADJ
                : bcd_reg[d*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W];
        end
    end

    always_comb
    begin
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        valid_next  = 1'b0;
        neg_next    = neg_reg;
        if (load)
        begin
            bin_next    = mag;
            bcd_next    = '0;
            cnt_next    = '0;
            active_next = 1'b1;
            neg_next    = neg;
        end
        else if (active_reg)
        begin
            bcd_next = {bcd_adj[sdf_pkg::BCD_W-2:0], bin_reg[sdf_pkg::VALUE_W-1]};
            bin_next = {bin_reg[sdf_pkg::VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sdf_pkg::SHIFT_W'(sdf_pkg::VALUE_W - 1))
            begin
                active_next = 1'b0;
                valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign active = active_reg | valid_reg;
    assign res    = '{valid: valid_reg, neg: neg_reg, bcd: bcd_reg};

endmodule

// ----- src/sdf_emit.sv -----
// Character emitter: sign, leading-zero skip and one ASCII digit per cycle.
`timescale 1ns / 1ps

module sdf_emit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  sdf_pkg::conv_res_t          res,
    output logic                        active,
    output logic [sdf_pkg::CHAR_W-1:0]  character,
    output logic                        last,
    output logic                        strobe
);

    sdf_pkg::em_state_t          state_reg, state_next;
    logic [sdf_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [sdf_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [sdf_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                        last_reg, last_next;
    logic                        strobe_reg, strobe_next;
    logic [sdf_pkg::DIGIT_W-1:0] top_digit;

    assign top_digit = bcd_reg[sdf_pkg::BCD_W-1 -: sdf_pkg::DIGIT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sdf_pkg::EM_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        bcd_next    = bcd_reg;
        rem_next    = rem_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        strobe_next = 1'b0;
        case (state_reg)
            sdf_pkg::EM_IDLE:
            begin
                if (res.valid)
                begin
                    bcd_next   = res.bcd;
                    rem_next   = sdf_pkg::REM_W'(sdf_pkg::DIGITS);
                    state_next = res.neg ? sdf_pkg::EM_SIGN : sdf_pkg::EM_SKIP;
                end
            end
            sdf_pkg::EM_SIGN:
            begin
                char_next   = sdf_pkg::CHAR_MINUS;
                last_next   = 1'b0;
                strobe_next = 1'b1;
                state_next  = sdf_pkg::EM_SKIP;
            end
            sdf_pkg::EM_SKIP:
            begin
                // The units digit is always printed, so zero gives a single '0'.
                if (top_digit == '0 && rem_reg != sdf_pkg::REM_W'(1))
                begin
                    bcd_next = {bcd_reg[sdf_pkg::BCD_W-sdf_pkg::DIGIT_W-1:0],
                                {sdf_pkg::DIGIT_W{1'b0}}};
                    rem_next = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = sdf_pkg::EM_DIGIT;
                end
            end
            sdf_pkg::EM_DIGIT:
            begin
                char_next   = sdf_pkg::CHAR_ZERO | {{(sdf_pkg::CHAR_W-sdf_pkg::DIGIT_W){1'b0}},
                                                   top_digit};
                last_next   = (rem_reg == sdf_pkg::REM_W'(1));
                strobe_next = 1'b1;
                bcd_next    = {bcd_reg[sdf_pkg::BCD_W-sdf_pkg::DIGIT_W-1:0],
                               {sdf_pkg::DIGIT_W{1'b0}}};
                rem_next    = rem_reg - 1'b1;
                if (rem_reg == sdf_pkg::REM_W'(1))
                begin
                    state_next = sdf_pkg::EM_IDLE;
                end
            end
            default:
            begin
                state_next = sdf_pkg::EM_IDLE;
            end
        endcase
    end

    assign active    = (state_reg != sdf_pkg::EM_IDLE);
    assign character = char_reg;
    assign last      = last_reg;
    assign strobe    = strobe_reg;

endmodule

// ----- src/sdf_checker.sv -----
// Port-level checks for the signed decimal formatter, bound to the top level.
`timescale 1ns / 1ps

module sdf_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [sdf_pkg::CHAR_W-1:0]  character,
    input logic                        last,
    input logic                        strobe
);

    // An accepted value keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted value");

    // Every beat carries a minus sign or a digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (character == sdf_pkg::CHAR_MINUS) ||
                   ((character >= sdf_pkg::CHAR_ZERO) && (character <= 8'd57)))
        else $error("beat carries a character that is neither sign nor digit");

    // The sign is never the final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (character == sdf_pkg::CHAR_MINUS) |-> !last)
        else $error("minus sign flagged as last");

    // While more beats are to come, the block stays busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("block idle before the last beat of a number");

    // The last beat is never directly followed by another beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("beat directly after the last beat");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .character (character),
    .last      (last),
    .strobe    (strobe)
);
